FILE: rtl/lpht_pkg.sv
// Types and constants shared by the linear probe hash table.
package lpht_pkg;

   localparam int SLOTS   = 1024;
   localparam int SLOT_AW = 10;
   localparam int CNT_W   = 11;
   localparam int HASH_W  = 32;
   localparam int CTR_W   = 32;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = HASH_W / DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_FIND   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_PROBE,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type              opcode;
      logic [HASH_W-1:0]   key_hash;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_AW-1:0]  slot_index;
      logic [CNT_W-1:0]    occupied_slots;
      logic [CTR_W-1:0]    collided_inserts;
      logic [CTR_W-1:0]    collision_probes;
   } rsp_type;

endpackage

FILE: rtl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing, one synchronous slot memory.
//
// Items enter on req_valid/req_stall (req_data: opcode, key_hash) and each gives
// one result on rsp_valid/rsp_stall. csr_we/csr_wdata write slots_in_use; a
// value of 0 acts as 1 and a value above 1024 acts as 1024.
// An insert into a full table skips the remainder unit and the search and answers ST_FULL.
// Otherwise the start slot comes from a remainder unit that retires 4 bits of
// the hash per cycle, then the slot memory is read one slot per cycle through
// its single read port; a find that misses checks every slot in use.
// One item is in flight at a time; the next item is accepted while the
// previous result still waits in the output register.
// After reset and after every csr write a clearing pass runs over all 1024
// slots with req_stall high; counters and occupancy restart at 0.
// A stalled result holds in the output register; the block finishes the
// current item and then holds with req_stall high until the result is taken.
module linear_probe_hash_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  lpht_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lpht_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [lpht_pkg::CNT_W-1:0]   csr_wdata
);

   lpht_pkg::state_type                 state_ff, state_in;
   logic [lpht_pkg::CNT_W-1:0]          csr_slots_ff;
   logic [lpht_pkg::CNT_W-1:0]          n_eff;

   lpht_pkg::op_type                    op_ff;
   logic [lpht_pkg::HASH_W-1:0]         hash_ff;
   logic [lpht_pkg::HASH_W-1:0]         div_q_ff;
   logic [lpht_pkg::SLOT_AW-1:0]        rem_ff, rem_in;
   logic [lpht_pkg::STEP_W-1:0]         step_ff;

   logic [lpht_pkg::SLOT_AW-1:0]        probe_ff, probe_wrap;
   logic [lpht_pkg::SLOT_AW-1:0]        chk_idx_ff;
   logic                                rd_pend_ff;
   logic [lpht_pkg::CNT_W-1:0]          iss_cnt_ff, chk_cnt_ff;
   logic [lpht_pkg::SLOT_AW-1:0]        clr_ff;

   logic [lpht_pkg::HASH_W:0]           mem_ram [lpht_pkg::SLOTS];
   logic [lpht_pkg::HASH_W:0]           rd_data_ff;
   logic                                mem_we;
   logic [lpht_pkg::SLOT_AW-1:0]        mem_waddr;
   logic [lpht_pkg::HASH_W:0]           mem_wdata;

   logic [lpht_pkg::CNT_W-1:0]          entry_ff;
   logic [lpht_pkg::CTR_W-1:0]          coll_ins_ff, coll_prb_ff;
   logic [lpht_pkg::CTR_W:0]            prb_sum;

   lpht_pkg::status_type                res_status_ff;
   logic [lpht_pkg::SLOT_AW-1:0]        res_idx_ff;
   logic                                rsp_valid_ff;
   lpht_pkg::rsp_type                   rsp_data_ff;

   logic req_take, issue, hit, last_chk, finish, is_full, rsp_load;

   always_comb begin
      if (csr_slots_ff == '0) begin
         n_eff = lpht_pkg::CNT_W'(1);
      end else if (csr_slots_ff > lpht_pkg::CNT_W'(lpht_pkg::SLOTS)) begin
         n_eff = lpht_pkg::CNT_W'(lpht_pkg::SLOTS);
      end else begin
         n_eff = csr_slots_ff;
      end
   end

   // restoring remainder, DIV_BITS bits of the dividend per cycle
   always_comb begin
      logic [lpht_pkg::SLOT_AW-1:0] r;
      logic [lpht_pkg::CNT_W-1:0]   t;
      r = rem_ff;
      t = '0;
      for (int k = 0; k < lpht_pkg::DIV_BITS; k++) begin
         t = {r, div_q_ff[lpht_pkg::HASH_W-1-k]};
         if (t >= n_eff) begin
            t = t - n_eff;
         end
         r = t[lpht_pkg::SLOT_AW-1:0];
      end
      rem_in = r;
   end

   assign probe_wrap = ({1'b0, probe_ff} + lpht_pkg::CNT_W'(1) == n_eff) ? '0
                       : probe_ff + lpht_pkg::SLOT_AW'(1);

   assign req_take = req_valid && !req_stall;
   assign is_full  = (req_data.opcode == lpht_pkg::OP_INSERT) && (entry_ff >= n_eff);
   assign issue    = (iss_cnt_ff != n_eff);
   assign hit      = rd_pend_ff && ((op_ff == lpht_pkg::OP_INSERT) ? !rd_data_ff[lpht_pkg::HASH_W]
                     : (rd_data_ff[lpht_pkg::HASH_W] &&
                        rd_data_ff[lpht_pkg::HASH_W-1:0] == hash_ff));
   assign last_chk = rd_pend_ff && (chk_cnt_ff + lpht_pkg::CNT_W'(1) == n_eff);
   assign finish   = hit || last_chk;
   assign rsp_load = (state_ff == lpht_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign prb_sum  = {1'b0, coll_prb_ff} + (lpht_pkg::CTR_W + 1)'(chk_cnt_ff);

   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = lpht_pkg::S_CLEAR;
      end else begin
         unique case (state_ff)
            lpht_pkg::S_CLEAR: begin
               if (clr_ff == lpht_pkg::SLOT_AW'(lpht_pkg::SLOTS - 1)) begin
                  state_in = lpht_pkg::S_IDLE;
               end
            end
            lpht_pkg::S_IDLE: begin
               if (req_take) begin
                  state_in = is_full ? lpht_pkg::S_DONE : lpht_pkg::S_DIV;
               end
            end
            lpht_pkg::S_DIV: begin
               if (step_ff == lpht_pkg::STEP_W'(lpht_pkg::DIV_STEPS - 1)) begin
                  state_in = lpht_pkg::S_PROBE;
               end
            end
            lpht_pkg::S_PROBE: begin
               if (finish) begin
                  state_in = lpht_pkg::S_DONE;
               end
            end
            lpht_pkg::S_DONE: begin
               if (rsp_load) begin
                  state_in = lpht_pkg::S_IDLE;
               end
            end
            default: state_in = lpht_pkg::S_CLEAR;
         endcase
      end
   end

   always_comb begin
      req_stall = (state_ff != lpht_pkg::S_IDLE);
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (state_ff == lpht_pkg::S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == lpht_pkg::S_PROBE && hit && op_ff == lpht_pkg::OP_INSERT) begin
         mem_we    = 1'b1;
         mem_waddr = chk_idx_ff;
         mem_wdata = {1'b1, hash_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ram[probe_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::S_CLEAR;
         csr_slots_ff <= lpht_pkg::CNT_W'(lpht_pkg::SLOTS);
         clr_ff       <= '0;
         entry_ff     <= '0;
         coll_ins_ff  <= '0;
         coll_prb_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            csr_slots_ff <= csr_wdata;
            clr_ff       <= '0;
            entry_ff     <= '0;
            coll_ins_ff  <= '0;
            coll_prb_ff  <= '0;
         end else begin
            if (state_ff == lpht_pkg::S_CLEAR) begin
               clr_ff <= clr_ff + lpht_pkg::SLOT_AW'(1);
            end
            if (state_ff == lpht_pkg::S_PROBE && hit && op_ff == lpht_pkg::OP_INSERT) begin
               entry_ff <= entry_ff + lpht_pkg::CNT_W'(1);
               if (chk_cnt_ff != '0) begin
                  if (!(&coll_ins_ff)) begin
                     coll_ins_ff <= coll_ins_ff + lpht_pkg::CTR_W'(1);
                  end
                  coll_prb_ff <= prb_sum[lpht_pkg::CTR_W] ? '1
                                 : prb_sum[lpht_pkg::CTR_W-1:0];
               end
            end
         end
         if (state_ff == lpht_pkg::S_PROBE) begin
            rd_pend_ff <= issue && !finish;
         end else begin
            rd_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lpht_pkg::S_IDLE && req_take) begin
         op_ff         <= req_data.opcode;
         hash_ff       <= req_data.key_hash;
         div_q_ff      <= req_data.key_hash;
         rem_ff        <= '0;
         step_ff       <= '0;
         res_status_ff <= lpht_pkg::ST_FULL;
         res_idx_ff    <= '0;
      end
      if (state_ff == lpht_pkg::S_DIV) begin
         div_q_ff   <= div_q_ff << lpht_pkg::DIV_BITS;
         rem_ff     <= rem_in;
         step_ff    <= step_ff + lpht_pkg::STEP_W'(1);
         probe_ff   <= rem_in;
         iss_cnt_ff <= '0;
         chk_cnt_ff <= '0;
      end
      if (state_ff == lpht_pkg::S_PROBE) begin
         if (issue) begin
            probe_ff   <= probe_wrap;
            iss_cnt_ff <= iss_cnt_ff + lpht_pkg::CNT_W'(1);
         end
         chk_idx_ff <= probe_ff;
         if (rd_pend_ff) begin
            chk_cnt_ff <= chk_cnt_ff + lpht_pkg::CNT_W'(1);
         end
         if (hit) begin
            res_status_ff <= (op_ff == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_INSERTED
                             : lpht_pkg::ST_FOUND;
            res_idx_ff    <= chk_idx_ff;
         end else if (last_chk) begin
            res_status_ff <= lpht_pkg::ST_NOT_FOUND;
            res_idx_ff    <= '0;
         end
      end
      if (rsp_load) begin
         rsp_data_ff.status           <= res_status_ff;
         rsp_data_ff.slot_index       <= res_idx_ff;
         rsp_data_ff.occupied_slots   <= entry_ff;
         rsp_data_ff.collided_inserts <= coll_ins_ff;
         rsp_data_ff.collision_probes <= coll_prb_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      entry_ff <= n_eff)
      else $error("occupancy exceeds slots in use");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == lpht_pkg::ST_INSERTED ||
                    rsp_data.status == lpht_pkg::ST_FOUND)
      |-> ({1'b0, rsp_data.slot_index} < n_eff))
      else $error("result slot outside slots in use");

   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == lpht_pkg::ST_NOT_FOUND ||
                    rsp_data.status == lpht_pkg::ST_FULL)
      |-> (rsp_data.slot_index == '0))
      else $error("slot index not zero on miss or full");

   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == lpht_pkg::S_PROBE && op_ff == lpht_pkg::OP_INSERT && last_chk
      |-> hit)
      else $error("insert found no free slot");

endmodule

FILE: tb/sv/linear_probe_hash_table_tb.sv
// Self-checking testbench for the linear probe hash table: directed and random inserts and finds.
module linear_probe_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   lpht_pkg::req_type             req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   lpht_pkg::rsp_type             rsp_data;
   logic                          csr_we = 1'b0;
   logic [lpht_pkg::CNT_W-1:0]    csr_wdata = '0;

   bit                            slot_used [lpht_pkg::SLOTS];
   logic [lpht_pkg::HASH_W-1:0]   slot_key [lpht_pkg::SLOTS];
   int unsigned                   entry_total;
   logic [lpht_pkg::CTR_W-1:0]    collided_total;
   logic [lpht_pkg::CTR_W-1:0]    probe_total;
   logic [lpht_pkg::CNT_W-1:0]    slots_reg;

   lpht_pkg::rsp_type             expected_rsp [$];
   lpht_pkg::rsp_type             want_rsp;
   int                            errors = 0;
   int                            items_sent = 0;
   int                            results_seen = 0;
   int                            csr_writes = 0;
   bit                            no_idle = 1'b0;

   linear_probe_hash_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_table(logic [lpht_pkg::CNT_W-1:0] v);
      slots_reg = v;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_key[i] = '0;
      end
      entry_total = 0;
      collided_total = '0;
      probe_total = '0;
   endfunction

   function automatic int unsigned live_slots(logic [lpht_pkg::CNT_W-1:0] v);
      if (v == 0) return 1;
      if (v > lpht_pkg::SLOTS) return lpht_pkg::SLOTS;
      return v;
   endfunction

   function automatic logic [lpht_pkg::CTR_W-1:0] sat_add(logic [lpht_pkg::CTR_W-1:0] a,
                                                          logic [lpht_pkg::CTR_W-1:0] b);
      logic [lpht_pkg::CTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[lpht_pkg::CTR_W] ? '1 : s[lpht_pkg::CTR_W-1:0];
   endfunction

   function automatic lpht_pkg::rsp_type predict_table_op(lpht_pkg::op_type op,
                                                          logic [lpht_pkg::HASH_W-1:0] h);
      int unsigned n;
      int unsigned slot;
      int unsigned passed;
      lpht_pkg::rsp_type r;
      n = live_slots(slots_reg);
      slot = h % n;
      r = '0;
      if (op == lpht_pkg::OP_INSERT) begin
         if (entry_total >= n) begin
            r.status = lpht_pkg::ST_FULL;
         end else begin
            passed = 0;
            while (slot_used[slot]) begin
               passed++;
               slot = (slot + 1 == n) ? 0 : slot + 1;
            end
            slot_used[slot] = 1'b1;
            slot_key[slot] = h;
            entry_total++;
            if (passed != 0) begin
               collided_total = sat_add(collided_total, 1);
               probe_total = sat_add(probe_total, passed);
            end
            r.status = lpht_pkg::ST_INSERTED;
            r.slot_index = lpht_pkg::SLOT_AW'(slot);
         end
      end else begin
         r.status = lpht_pkg::ST_NOT_FOUND;
         for (int i = 0; i < n; i++) begin
            if (slot_used[slot] && slot_key[slot] == h) begin
               r.status = lpht_pkg::ST_FOUND;
               r.slot_index = lpht_pkg::SLOT_AW'(slot);
               break;
            end
            slot = (slot + 1 == n) ? 0 : slot + 1;
         end
      end
      r.occupied_slots = lpht_pkg::CNT_W'(entry_total);
      r.collided_inserts = collided_total;
      r.collision_probes = probe_total;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("[%0t] mismatch on result %0d, %s: got %0h, want %0h",
               $realtime, results_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.status, 0);
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", rsp_data.status, want_rsp.status);
            if (rsp_data.slot_index !== want_rsp.slot_index)
               report_mismatch("slot_index", rsp_data.slot_index, want_rsp.slot_index);
            if (rsp_data.occupied_slots !== want_rsp.occupied_slots)
               report_mismatch("occupied_slots", rsp_data.occupied_slots,
                               want_rsp.occupied_slots);
            if (rsp_data.collided_inserts !== want_rsp.collided_inserts)
               report_mismatch("collided_inserts", rsp_data.collided_inserts,
                               want_rsp.collided_inserts);
            if (rsp_data.collision_probes !== want_rsp.collision_probes)
               report_mismatch("collision_probes", rsp_data.collision_probes,
                               want_rsp.collision_probes);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 38);
   end

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(lpht_pkg::op_type op, logic [lpht_pkg::HASH_W-1:0] h);
      lpht_pkg::req_type item;
      item.opcode = op;
      item.key_hash = h;
      while (!no_idle && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(predict_table_op(op, h));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic set_slots(logic [lpht_pkg::CNT_W-1:0] v);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      clear_table(v);
      csr_writes++;
   endtask

   task automatic test_default_size();
      send_item(lpht_pkg::OP_FIND, 32'h0000_0000);
      send_item(lpht_pkg::OP_INSERT, 32'h0000_0000);
      send_item(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_item(lpht_pkg::OP_INSERT, 32'd1023);
      send_item(lpht_pkg::OP_INSERT, 32'h0000_0000);
      send_item(lpht_pkg::OP_FIND, 32'h0000_0000);
      send_item(lpht_pkg::OP_FIND, 32'd1023);
      send_item(lpht_pkg::OP_FIND, 32'h8000_0000);
   endtask

   task automatic test_zero_and_one_slot();
      set_slots(lpht_pkg::CNT_W'(0));
      send_item(lpht_pkg::OP_INSERT, 32'hAAAA_5555);
      send_item(lpht_pkg::OP_INSERT, 32'h5555_AAAA);
      send_item(lpht_pkg::OP_FIND, 32'h5555_AAAA);
      send_item(lpht_pkg::OP_FIND, 32'hAAAA_5555);
      set_slots(lpht_pkg::CNT_W'(1));
      send_item(lpht_pkg::OP_INSERT, 32'd7);
      send_item(lpht_pkg::OP_INSERT, 32'd7);
   endtask

   task automatic test_oversize_setting();
      set_slots('1);
      send_item(lpht_pkg::OP_INSERT, 32'h0000_0400);
      send_item(lpht_pkg::OP_FIND, 32'h0000_0400);
      set_slots(lpht_pkg::CNT_W'(lpht_pkg::SLOTS + 1));
      send_item(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF);
   endtask

   task automatic test_wrap_and_full();
      set_slots(lpht_pkg::CNT_W'(3));
      send_item(lpht_pkg::OP_INSERT, 32'd2);
      send_item(lpht_pkg::OP_INSERT, 32'd2);
      send_item(lpht_pkg::OP_INSERT, 32'd2);
      send_item(lpht_pkg::OP_INSERT, 32'd5);
      send_item(lpht_pkg::OP_FIND, 32'd2);
      send_item(lpht_pkg::OP_FIND, 32'd8);
   endtask

   task automatic test_random_mix();
      logic [lpht_pkg::HASH_W-1:0] keys [$];
      logic [lpht_pkg::HASH_W-1:0] h;
      int unsigned                 phase;
      int unsigned                 start;
      int unsigned                 setting;
      int unsigned                 eff;
      int unsigned                 count;
      int unsigned                 pick;
      bit                          big;
      phase = 0;
      start = items_sent;
      while (items_sent - start < 1000) begin
         big = (phase % 6 == 5);
         if (big) begin
            case ($urandom_range(3))
               0: setting = lpht_pkg::SLOTS;
               1: setting = 2047;
               2: setting = lpht_pkg::SLOTS + 1;
               default: setting = $urandom_range(65, lpht_pkg::SLOTS - 1);
            endcase
         end else if (phase == 2) begin
            setting = 64;
         end else begin
            setting = $urandom_range(0, 64);
         end
         set_slots(lpht_pkg::CNT_W'(setting));
         eff = live_slots(lpht_pkg::CNT_W'(setting));
         count = big ? 40 : 3 * eff + $urandom_range(2, 8);
         no_idle = (phase == 2);
         keys.delete();
         repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               case ($urandom_range(2))
                  0: h = $urandom;
                  1: h = $urandom_range(0, eff - 1) + eff * $urandom_range(0, 3);
                  default: h = (keys.size() != 0) ? keys[$urandom_range(keys.size() - 1)]
                                                  : $urandom;
               endcase
               keys.push_back(h);
               send_item(lpht_pkg::OP_INSERT, h);
            end else if (pick < 85 && keys.size() != 0) begin
               send_item(lpht_pkg::OP_FIND, keys[$urandom_range(keys.size() - 1)]);
            end else if (!big || pick >= 97) begin
               send_item(lpht_pkg::OP_FIND, $urandom);
            end else begin
               send_item(lpht_pkg::OP_INSERT, $urandom);
            end
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_table(lpht_pkg::CNT_W'(lpht_pkg::SLOTS));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_size();
      test_zero_and_one_slot();
      test_oversize_setting();
      test_wrap_and_full();
      test_random_mix();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Ran %0d inserts/finds, checked %0d results across %0d table sizes, %0d mismatches",
               items_sent, results_seen, csr_writes + 1, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Timed out with %0d results outstanding", expected_rsp.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
